// ===== rtl/pal_pkg.sv =====
package pal_pkg;

  // sine table geometry
  localparam int SINE_DEPTH = 256;
  localparam int SINE_LOG2  = $clog2(SINE_DEPTH);
  localparam int PH_W       = SINE_LOG2 + 2;

  // fixed point constants
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint INV_PI_Q32 = 64'sd1367130551;
  localparam int     ONE_Q14    = 16384;
  localparam int     TWO_DEG    = 143;
  localparam int     VS_LIMIT   = 1300;
  localparam int     ALT_ERR_LIM = 976;
  localparam int     INTEG_LIM  = 65536;

  // reciprocals for the constant divisions
  localparam int RECIP3      = 21846;
  localparam int RECIP3_SH   = 16;
  localparam int RECIP5      = 3355444;
  localparam int RECIP5_SH   = 24;
  localparam int RECIP125    = 2147484;
  localparam int RECIP125_SH = 28;

  // serial divider width
  localparam int DIV_W   = 26;
  localparam int DIV_CW  = $clog2(DIV_W + 1);

  // mode codes
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_ALT   = 3'd1;
  localparam logic [2:0] MODE_VS    = 3'd2;
  localparam logic [2:0] MODE_PITCH = 3'd3;
  localparam logic [2:0] MODE_PATH  = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_TGT_ALT  = 3'd1;
  localparam logic [2:0] CFG_TGT_VS   = 3'd2;
  localparam logic [2:0] CFG_TGT_PIT  = 3'd3;
  localparam logic [2:0] CFG_TGT_PATH = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_ALT, S_DIV_START, S_DIV_WAIT, S_GAMMA, S_ROLL, S_TRIG,
    S_RATE, S_ERR, S_CAND, S_FULL, S_FIN, S_PASS
  } pal_state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_ALT, OP_DIV, OP_GAMMA, OP_ROLL, OP_TRIG,
    OP_RATE, OP_ERR, OP_CAND, OP_FULL, OP_OUT
  } pal_op_t;

  typedef struct packed {
    pal_op_t op;
    logic    pass;
    logic    sel_pitch;
  } pal_cmd_t;

  typedef struct packed {
    logic div_done;
  } pal_stat_t;

  typedef logic [14:0] sine_rom_t [SINE_DEPTH];

  // signed division truncated toward zero, by shift and subtract
  function automatic longint div_trunc(input longint n, input longint d);
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] qt;
    logic [64:0] rm;
    un = (n < 0) ? 64'(-n) : 64'(n);
    ud = (d < 0) ? 64'(-d) : 64'(d);
    qt = '0;
    rm = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[63:0], un[i]};
      if (rm >= {1'b0, ud}) begin
        rm    = rm - {1'b0, ud};
        qt[i] = 1'b1;
      end
    end
    return ((n < 0) != (d < 0)) ? -longint'(qt) : longint'(qt);
  endfunction

  // quarter-wave sine in Q1.14 by a Q30 Taylor series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    x;
    longint    term;
    longint    sum;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x    = div_trunc(longint'(k) * PI_Q30, longint'(2 * SINE_DEPTH));
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = div_trunc(term * x, 64'sd1 <<< 30);
        term = div_trunc(term * x, 64'sd1 <<< 30);
        term = -div_trunc(term, longint'((2 * n) * (2 * n + 1)));
        sum  = sum + term;
      end
      if (sum < 0) sum = 0;
      rom[k] = 15'(div_trunc(sum * longint'(ONE_Q14) + (64'sd1 <<< 29), 64'sd1 <<< 30));
    end
    return rom;
  endfunction

endpackage

// ===== rtl/pal_div.sv =====
module pal_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pal_pkg::DIV_W-1:0]  num,
  input  logic [15:0]                den,
  output logic                       done,
  output logic [pal_pkg::DIV_W-1:0]  quo
);

  logic [pal_pkg::DIV_W-1:0]  acc_r, acc_nxt;
  logic [15:0]                rem_r, rem_nxt;
  logic [15:0]                den_r;
  logic [pal_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic [16:0]                shifted;
  logic                       ge;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r, acc_r[pal_pkg::DIV_W-1]};
    ge      = shifted >= {1'b0, den_r};
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = num;
      rem_nxt = '0;
      cnt_nxt = pal_pkg::DIV_CW'(pal_pkg::DIV_W);
    end else if (cnt_r != '0) begin
      acc_nxt  = {acc_r[pal_pkg::DIV_W-2:0], ge};
      rem_nxt  = ge ? 16'(shifted - {1'b0, den_r}) : shifted[15:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == pal_pkg::DIV_CW'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = acc_r;

endmodule

// ===== rtl/pal_ctrl.sv =====
module pal_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          pitch_mode,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pal_pkg::pal_stat_t  stat,
  output pal_pkg::pal_cmd_t   cmd
);

  pal_pkg::pal_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pal_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (pitch_mode)
            pal_pkg::MODE_ALT:   state_nxt = pal_pkg::S_ALT;
            pal_pkg::MODE_VS:    state_nxt = pal_pkg::S_DIV_START;
            pal_pkg::MODE_PITCH: state_nxt = pal_pkg::S_ROLL;
            pal_pkg::MODE_PATH:  state_nxt = pal_pkg::S_ROLL;
            default:             state_nxt = pal_pkg::S_PASS;
          endcase
        end
      end
      pal_pkg::S_ALT:       state_nxt = pal_pkg::S_DIV_START;
      pal_pkg::S_DIV_START: state_nxt = pal_pkg::S_DIV_WAIT;
      pal_pkg::S_DIV_WAIT:  if (stat.div_done) state_nxt = pal_pkg::S_GAMMA;
      pal_pkg::S_GAMMA:     state_nxt = pal_pkg::S_ROLL;
      pal_pkg::S_ROLL:      state_nxt = pal_pkg::S_TRIG;
      pal_pkg::S_TRIG:      state_nxt = pal_pkg::S_RATE;
      pal_pkg::S_RATE:      state_nxt = pal_pkg::S_ERR;
      pal_pkg::S_ERR:       state_nxt = pal_pkg::S_CAND;
      pal_pkg::S_CAND:      state_nxt = pal_pkg::S_FULL;
      pal_pkg::S_FULL:      state_nxt = pal_pkg::S_FIN;
      pal_pkg::S_FIN:       if (out_free) state_nxt = pal_pkg::S_IDLE;
      pal_pkg::S_PASS:      if (out_free) state_nxt = pal_pkg::S_IDLE;
      default:              state_nxt = pal_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready      = (state_r == pal_pkg::S_IDLE);
    cmd.op        = pal_pkg::OP_IDLE;
    cmd.pass      = (state_r == pal_pkg::S_PASS);
    cmd.sel_pitch = (pitch_mode == pal_pkg::MODE_PITCH);
    unique case (state_r)
      pal_pkg::S_IDLE:      if (in_valid) cmd.op = pal_pkg::OP_LOAD;
      pal_pkg::S_ALT:       cmd.op = pal_pkg::OP_ALT;
      pal_pkg::S_DIV_START: cmd.op = pal_pkg::OP_DIV;
      pal_pkg::S_DIV_WAIT:  cmd.op = pal_pkg::OP_IDLE;
      pal_pkg::S_GAMMA:     cmd.op = pal_pkg::OP_GAMMA;
      pal_pkg::S_ROLL:      cmd.op = pal_pkg::OP_ROLL;
      pal_pkg::S_TRIG:      cmd.op = pal_pkg::OP_TRIG;
      pal_pkg::S_RATE:      cmd.op = pal_pkg::OP_RATE;
      pal_pkg::S_ERR:       cmd.op = pal_pkg::OP_ERR;
      pal_pkg::S_CAND:      cmd.op = pal_pkg::OP_CAND;
      pal_pkg::S_FULL:      cmd.op = pal_pkg::OP_FULL;
      pal_pkg::S_FIN:       if (out_free) cmd.op = pal_pkg::OP_OUT;
      pal_pkg::S_PASS:      if (out_free) cmd.op = pal_pkg::OP_OUT;
      default:              cmd.op = pal_pkg::OP_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == pal_pkg::OP_OUT) out_valid_nxt = 1'b1;
    else if (out_ready)            out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pal_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/pal_dp.sv =====
module pal_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pal_pkg::pal_cmd_t   cmd,
  output pal_pkg::pal_stat_t  stat,
  input  logic signed [23:0]  tgt_alt,
  input  logic signed [15:0]  tgt_vs,
  input  logic signed [15:0]  tgt_pitch,
  input  logic signed [15:0]  tgt_path,
  input  logic signed [23:0]  altitude_down,
  input  logic [15:0]         airspeed,
  input  logic signed [15:0]  pitch_angle,
  input  logic signed [15:0]  attack_angle,
  input  logic signed [15:0]  pitch_rate,
  input  logic signed [15:0]  yaw_rate,
  input  logic signed [15:0]  roll_angle,
  input  logic signed [15:0]  forward_accel,
  input  logic signed [15:0]  pilot_elevator,
  output logic signed [15:0]  elevator_cmd
);

  localparam pal_pkg::sine_rom_t SINE_ROM = pal_pkg::build_sine_rom();
  localparam int J_W = pal_pkg::SINE_LOG2;

  // captured item
  logic signed [23:0] alt_r;
  logic [15:0]        vc_r;
  logic signed [15:0] pitch_r, alpha_r, q_r, r_r, roll_r, fa_r, pilot_r;

  // working registers
  logic signed [15:0] vs_r, gc_r, sn_r, cs_r;
  logic signed [47:0] roll_prod_r;
  logic [21:0]        m5_r, m125_r;
  logic               neg5_r, neg125_r;
  logic signed [31:0] qc_r, rs_r;
  logic [43:0]        p5_r, p125_r;
  logic signed [23:0] e_r;
  logic signed [31:0] cand_r;
  logic signed [39:0] full_r;
  logic signed [31:0] pint_r, gint_r;
  logic signed [15:0] out_r;

  // altitude error to vertical speed demand
  logic signed [24:0] alt_err;
  logic [9:0]         alt_mag;
  logic [11:0]        alt_x;
  logic [26:0]        alt_prod;
  logic [10:0]        alt_q, alt_lim;
  logic signed [15:0] vs_alt;

  always_comb begin
    alt_err = {alt_r[23], alt_r} - {tgt_alt[23], tgt_alt};
    if (alt_err > 25'sd976 || alt_err < -25'sd976) alt_mag = 10'(pal_pkg::ALT_ERR_LIM);
    else if (alt_err[24])                          alt_mag = 10'(-alt_err);
    else                                           alt_mag = 10'(alt_err);
    alt_x    = {alt_mag, 2'b00} + 12'd1;
    alt_prod = 27'(alt_x) * 27'(pal_pkg::RECIP3);
    alt_q    = alt_prod[pal_pkg::RECIP3_SH +: 11];
    alt_lim  = (alt_q > 11'(pal_pkg::VS_LIMIT)) ? 11'(pal_pkg::VS_LIMIT) : alt_q;
    vs_alt   = alt_err[24] ? -16'(alt_lim) : 16'(alt_lim);
  end

  // divider operands and saturated path angle demand
  logic [15:0]                 vs_mag;
  logic [pal_pkg::DIV_W-1:0]   div_num, div_quo;
  logic [15:0]                 div_den;
  logic                        div_done;
  logic signed [15:0]          gamma_c;

  always_comb begin
    vs_mag  = vs_r[15] ? 16'(-vs_r) : 16'(vs_r);
    div_num = {vs_mag, 10'b0};
    div_den = (vc_r == 16'd0) ? 16'd1 : vc_r;
    if (vs_r[15]) begin
      gamma_c = (div_quo > pal_pkg::DIV_W'(32768)) ? -16'sd32768 : -16'(div_quo);
    end else begin
      gamma_c = (div_quo > pal_pkg::DIV_W'(32767)) ? 16'sd32767 : 16'(div_quo);
    end
  end

  pal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == pal_pkg::OP_DIV),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign stat.div_done = div_done;

  // path error operands and roll phase product
  logic signed [17:0] d18;
  logic signed [21:0] x5, x125;
  logic [21:0]        m5, m125;
  logic signed [47:0] roll_prod;

  always_comb begin
    d18       = 18'(gc_r) - 18'(pitch_r) + 18'(alpha_r);
    x5        = {d18, 4'b0000};
    m5        = x5[21] ? 22'(-x5) + 22'd4 : 22'(x5);
    x125      = 22'(fa_r) * 22'sd48;
    m125      = x125[21] ? 22'(-x125) + 22'd124 : 22'(x125);
    roll_prod = 48'(roll_r) * 48'(pal_pkg::INV_PI_Q32);
  end

  // table lookup of sine and cosine
  logic signed [63:0]  ph_wide;
  logic [pal_pkg::PH_W-1:0] ph;
  logic [1:0]          quad;
  logic [J_W-1:0]      j, jn;
  logic signed [15:0]  s_val, c_val, sn, cs;

  always_comb begin
    ph_wide = (64'(roll_prod_r) <<< (pal_pkg::SINE_LOG2 + 1)) + (64'sd1 <<< 43);
    ph      = ph_wide[44 +: pal_pkg::PH_W];
    quad    = ph[pal_pkg::PH_W-1 -: 2];
    j       = ph[J_W-1:0];
    jn      = -j;
    s_val   = 16'(SINE_ROM[j]);
    c_val   = (j == '0) ? 16'(pal_pkg::ONE_Q14) : 16'(SINE_ROM[jn]);
    unique case (quad)
      2'd0: begin sn = s_val;  cs = c_val;  end
      2'd1: begin sn = c_val;  cs = -s_val; end
      2'd2: begin sn = -s_val; cs = -c_val; end
      default: begin sn = -c_val; cs = s_val; end
    endcase
  end

  // loop error
  logic signed [23:0] rate, f1, f2, e_path, e_pitch, e_val;
  logic signed [16:0] dp;
  logic signed [8:0]  dp_lim;

  always_comb begin
    rate    = -24'(qc_r >>> 10) + 24'(rs_r >>> 10);
    f1      = neg5_r ? -24'(p5_r[pal_pkg::RECIP5_SH +: 20])
                     : 24'(p5_r[pal_pkg::RECIP5_SH +: 20]);
    f2      = neg125_r ? -24'(p125_r[pal_pkg::RECIP125_SH +: 16])
                       : 24'(p125_r[pal_pkg::RECIP125_SH +: 16]);
    e_path  = f1 + rate - f2;
    dp      = 17'(tgt_pitch) - 17'(pitch_r);
    if (dp > 17'sd143)       dp_lim = 9'sd143;
    else if (dp < -17'sd143) dp_lim = -9'sd143;
    else                     dp_lim = 9'(dp);
    e_pitch = (24'(dp_lim) <<< 4) + rate;
    e_val   = cmd.sel_pitch ? e_pitch : e_path;
  end

  // integrator candidate and loop output
  logic signed [31:0] integ;
  logic signed [32:0] cand_sum;
  logic signed [31:0] cand;
  logic signed [39:0] full;
  logic signed [39:0] out_sh;
  logic signed [15:0] out_lim;
  logic               in_band;

  always_comb begin
    integ    = cmd.sel_pitch ? pint_r : gint_r;
    cand_sum = 33'(integ) + 33'(e_r);
    if (cand_sum > 33'sd2147483647)       cand = 32'sh7fffffff;
    else if (cand_sum < -33'sd2147483648) cand = 32'sh80000000;
    else                                  cand = 32'(cand_sum);
    full     = -(40'(e_r) * 40'sd50) - (40'(cand_r) * 40'sd5);
    out_sh   = (full_r + 40'sd2) >>> 2;
    if (out_sh > 40'sd16384)       out_lim = 16'sd16384;
    else if (out_sh < -40'sd16384) out_lim = -16'sd16384;
    else                           out_lim = 16'(out_sh);
    in_band  = (full_r > -40'sd65536) && (full_r < 40'sd65536);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pal_pkg::OP_LOAD: begin
        alt_r   <= altitude_down;
        vc_r    <= airspeed;
        pitch_r <= pitch_angle;
        alpha_r <= attack_angle;
        q_r     <= pitch_rate;
        r_r     <= yaw_rate;
        roll_r  <= roll_angle;
        fa_r    <= forward_accel;
        pilot_r <= pilot_elevator;
        vs_r    <= tgt_vs;
        gc_r    <= tgt_path;
      end
      pal_pkg::OP_ALT:   vs_r <= vs_alt;
      pal_pkg::OP_GAMMA: gc_r <= gamma_c;
      pal_pkg::OP_ROLL: begin
        roll_prod_r <= roll_prod;
        m5_r        <= m5;
        neg5_r      <= x5[21];
        m125_r      <= m125;
        neg125_r    <= x125[21];
      end
      pal_pkg::OP_TRIG: begin
        sn_r <= sn;
        cs_r <= cs;
      end
      pal_pkg::OP_RATE: begin
        qc_r   <= q_r * cs_r;
        rs_r   <= r_r * sn_r;
        p5_r   <= 44'(m5_r) * 44'(pal_pkg::RECIP5);
        p125_r <= 44'(m125_r) * 44'(pal_pkg::RECIP125);
      end
      pal_pkg::OP_ERR:  e_r    <= e_val;
      pal_pkg::OP_CAND: cand_r <= cand;
      pal_pkg::OP_FULL: full_r <= full;
      pal_pkg::OP_OUT:  out_r  <= cmd.pass ? pilot_r : out_lim;
      default: ;
    endcase
  end

  // integrators, updated only while the loop output is unsaturated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pint_r <= '0;
      gint_r <= '0;
    end else if (cmd.op == pal_pkg::OP_OUT && !cmd.pass && in_band) begin
      if (cmd.sel_pitch) pint_r <= cand_r;
      else               gint_r <= cand_r;
    end
  end

  assign elevator_cmd = out_r;

endmodule

// ===== rtl/pitch_autopilot_elevator_law_unit.sv =====
// pitch autopilot elevator law
// input channel: one frame of aircraft state per item (in_valid / in_ready);
// result channel: one elevator command per item (out_valid / out_ready).
// config port: cfg_we writes cfg_wdata to register cfg_index (0 mode,
// 1 altitude, 2 vertical speed, 3 pitch, 4 path angle targets); indexes
// above 4 are ignored. write only while the block is idle.
// in vertical-speed and altitude hold the 26-step serial divider dominates
// the time to a result; pitch and path hold skip it, and pass-through modes
// skip all of the law steps.
// one item is worked on at a time; in_ready rises again as the result
// is written to the output register, so a new item can be accepted while
// the previous result still waits.
// if the receiver stalls, the finished result stays in the output register
// and the next item stops at its final step until the register frees.
// reset clears the mode and targets to zero, both integrators to zero and
// empties the output register.
module pitch_autopilot_elevator_law_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_altitude_down,
  input  logic [15:0]        in_airspeed,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_attack_angle,
  input  logic signed [15:0] in_pitch_rate,
  input  logic signed [15:0] in_yaw_rate,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_forward_accel,
  input  logic signed [15:0] in_pilot_elevator,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_elevator_cmd,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  logic [2:0]         mode_r;
  logic signed [23:0] tgt_alt_r;
  logic signed [15:0] tgt_vs_r, tgt_pitch_r, tgt_path_r;

  pal_pkg::pal_cmd_t  cmd;
  pal_pkg::pal_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= pal_pkg::MODE_NONE;
      tgt_alt_r   <= '0;
      tgt_vs_r    <= '0;
      tgt_pitch_r <= '0;
      tgt_path_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pal_pkg::CFG_MODE:     mode_r      <= cfg_wdata[2:0];
        pal_pkg::CFG_TGT_ALT:  tgt_alt_r   <= cfg_wdata;
        pal_pkg::CFG_TGT_VS:   tgt_vs_r    <= cfg_wdata[15:0];
        pal_pkg::CFG_TGT_PIT:  tgt_pitch_r <= cfg_wdata[15:0];
        pal_pkg::CFG_TGT_PATH: tgt_path_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  pal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .pitch_mode (mode_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pal_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .tgt_alt        (tgt_alt_r),
    .tgt_vs         (tgt_vs_r),
    .tgt_pitch      (tgt_pitch_r),
    .tgt_path       (tgt_path_r),
    .altitude_down  (in_altitude_down),
    .airspeed       (in_airspeed),
    .pitch_angle    (in_pitch_angle),
    .attack_angle   (in_attack_angle),
    .pitch_rate     (in_pitch_rate),
    .yaw_rate       (in_yaw_rate),
    .roll_angle     (in_roll_angle),
    .forward_accel  (in_forward_accel),
    .pilot_elevator (in_pilot_elevator),
    .elevator_cmd   (out_elevator_cmd)
  );

endmodule

// ===== rtl/pal_chk.sv =====
module pal_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_elevator_cmd
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_elevator_cmd))
    else $error("result dropped or changed while stalled");

  // command always inside plus or minus one
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_elevator_cmd <= 16'sd16384 && out_elevator_cmd >= -16'sd16384))
    else $error("elevator command out of range");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

bind pitch_autopilot_elevator_law_unit pal_chk u_pal_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_elevator_cmd (out_elevator_cmd)
);

// ===== sim/tb_pitch_autopilot_elevator_law_unit.sv =====
`timescale 1ns / 1ps

module tb_pitch_autopilot_elevator_law_unit;

  // spare mode codes act as pass-through; index above the register file is dropped
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [2:0] CFG_NONE_IDX  = 3'd7;

  // fixed point constants of the law
  localparam int     QSINE_N   = 256;
  localparam longint K_PI_Q30  = 64'sd3373259426;
  localparam longint K_INVPI   = 64'sd1367130551;
  localparam longint K_UNITY   = 16384;
  localparam longint K_PITCHLIM = 143;
  localparam longint K_VSLIM   = 1300;
  localparam longint K_INTLIM  = 65536;

  localparam int DIR_ROWS    = 20;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 85;
  localparam int SETTLE      = 60;

  typedef struct packed {
    logic signed [23:0] alt;
    logic [15:0]        speed;
    logic signed [15:0] pitch;
    logic signed [15:0] aoa;
    logic signed [15:0] q;
    logic signed [15:0] r;
    logic signed [15:0] roll;
    logic signed [15:0] ax;
    logic signed [15:0] pilot;
  } frame_t;

  typedef struct {
    logic [2:0]         mode;
    frame_t             f;
    bit                 known;
    logic signed [15:0] cmd;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] in_altitude_down;
  logic [15:0]        in_airspeed;
  logic signed [15:0] in_pitch_angle;
  logic signed [15:0] in_attack_angle;
  logic signed [15:0] in_pitch_rate;
  logic signed [15:0] in_yaw_rate;
  logic signed [15:0] in_roll_angle;
  logic signed [15:0] in_forward_accel;
  logic signed [15:0] in_pilot_elevator;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_elevator_cmd;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_wdata;

  pitch_autopilot_elevator_law_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_altitude_down  (in_altitude_down),
    .in_airspeed       (in_airspeed),
    .in_pitch_angle    (in_pitch_angle),
    .in_attack_angle   (in_attack_angle),
    .in_pitch_rate     (in_pitch_rate),
    .in_yaw_rate       (in_yaw_rate),
    .in_roll_angle     (in_roll_angle),
    .in_forward_accel  (in_forward_accel),
    .in_pilot_elevator (in_pilot_elevator),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_elevator_cmd  (out_elevator_cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // predictor copy of registers and loop state
  logic [2:0] law_mode;
  longint     tgt_alt;
  longint     tgt_vs;
  longint     tgt_pitch;
  longint     tgt_path;
  longint     pitch_integ;
  longint     path_integ;
  longint     qsine [QSINE_N];

  logic signed [15:0] cmd_pending_q [$];
  int                 mism_count;
  int                 tx_idle_pct;
  int                 rx_stall_pct;
  int                 rx_hold_cycles;
  dir_row_t           dir_tab [DIR_ROWS];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** pitch_autopilot_elevator_law_unit: FAILED **");
    $finish;
  end

  function automatic longint floor_div(input longint n, input longint d);
    longint quo;
    quo = n / d;
    if ((n % d) != 0 && n < 0) quo = quo - 1;
    return quo;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // quarter-wave sine, Q30 Taylor series rounded to Q1.14
  task automatic fill_qsine();
    longint x;
    longint t;
    longint acc;
    for (int k = 0; k < QSINE_N; k++) begin
      x   = (longint'(k) * K_PI_Q30) / longint'(2 * QSINE_N);
      t   = x;
      acc = x;
      for (int n = 1; n <= 7; n++) begin
        t   = (t * x) / (64'sd1 <<< 30);
        t   = (t * x) / (64'sd1 <<< 30);
        t   = -t / longint'((2 * n) * (2 * n + 1));
        acc = acc + t;
      end
      if (acc < 0) acc = 0;
      qsine[k] = (acc * K_UNITY + (64'sd1 <<< 29)) / (64'sd1 <<< 30);
    end
  endtask

  function automatic longint phase_sin(input longint ph);
    longint quad;
    longint j;
    quad = (ph / QSINE_N) & 3;
    j    = ph % QSINE_N;
    case (quad)
      0: return qsine[j];
      1: return (j == 0) ? K_UNITY : qsine[QSINE_N - j];
      2: return -qsine[j];
      default: return (j == 0) ? -K_UNITY : -qsine[QSINE_N - j];
    endcase
  endfunction

  // -q cos(roll) + r sin(roll) in 2^-16 rad/s
  function automatic longint rate_part(input frame_t f);
    longint p;
    longint ph;
    p  = longint'(f.roll) * (2 * QSINE_N) * K_INVPI;
    ph = ((p + (64'sd1 <<< 43)) >>> 44) & (4 * QSINE_N - 1);
    return -floor_div(longint'(f.q) * phase_sin((ph + QSINE_N) % (4 * QSINE_N)), 1024)
           + floor_div(longint'(f.r) * phase_sin(ph), 1024);
  endfunction

  // pi loop with conditional integration
  function automatic longint pi_step(input bit on_pitch, input longint e);
    longint cand;
    longint full;
    cand = clip((on_pitch ? pitch_integ : path_integ) + e, -64'sd2147483648, 64'sd2147483647);
    full = -50 * e - 5 * cand;
    if (full > -K_INTLIM && full < K_INTLIM) begin
      if (on_pitch) pitch_integ = cand;
      else path_integ = cand;
    end
    return clip(floor_div(full + 2, 4), -K_UNITY, K_UNITY);
  endfunction

  function automatic longint path_step(input frame_t f, input longint gc);
    longint e;
    e = floor_div((gc - (longint'(f.pitch) - longint'(f.aoa))) * 16, 5) + rate_part(f)
        - floor_div(longint'(f.ax) * 48, 125);
    return pi_step(1'b0, e);
  endfunction

  function automatic longint vs_step(input frame_t f, input longint vs);
    longint spd;
    spd = (f.speed == 0) ? 1 : longint'(f.speed);
    return path_step(f, clip(vs * 1024 / spd, -32768, 32767));
  endfunction

  function automatic logic signed [15:0] elevator_for(input frame_t f);
    longint num;
    longint vs;
    case (law_mode)
      pal_pkg::MODE_ALT: begin
        num = (longint'(f.alt) - tgt_alt) * 4;
        vs  = (num >= 0) ? (num + 1) / 3 : -((-num + 1) / 3);
        return 16'(vs_step(f, clip(vs, -K_VSLIM, K_VSLIM)));
      end
      pal_pkg::MODE_VS:    return 16'(vs_step(f, tgt_vs));
      pal_pkg::MODE_PITCH: return 16'(pi_step(1'b1,
                    clip(tgt_pitch - longint'(f.pitch), -K_PITCHLIM, K_PITCHLIM) * 16
                    + rate_part(f)));
      pal_pkg::MODE_PATH:  return 16'(path_step(f, tgt_path));
      default:    return f.pilot;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mism_count++;
  endtask

  // register write, block idle
  task automatic write_reg(input logic [2:0] idx, input longint val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 24'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      pal_pkg::CFG_MODE:     law_mode  = 3'(val);
      pal_pkg::CFG_TGT_ALT:  tgt_alt   = longint'($signed(24'(val)));
      pal_pkg::CFG_TGT_VS:   tgt_vs    = longint'($signed(16'(val)));
      pal_pkg::CFG_TGT_PIT:  tgt_pitch = longint'($signed(16'(val)));
      pal_pkg::CFG_TGT_PATH: tgt_path  = longint'($signed(16'(val)));
      default: ;
    endcase
  endtask

  // stop offering and wait until all commands are back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cmd_pending_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // offer one frame and hold it until accepted
  task automatic send_frame(input frame_t f, input bit known, input logic signed [15:0] cmd);
    logic signed [15:0] pred;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid          <= 1'b1;
    in_altitude_down  <= f.alt;
    in_airspeed       <= f.speed;
    in_pitch_angle    <= f.pitch;
    in_attack_angle   <= f.aoa;
    in_pitch_rate     <= f.q;
    in_yaw_rate       <= f.r;
    in_roll_angle     <= f.roll;
    in_forward_accel  <= f.ax;
    in_pilot_elevator <= f.pilot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = elevator_for(f);
    cmd_pending_q.push_back(known ? cmd : pred);
  endtask

  function automatic frame_t mk_frame(input longint alt, input longint spd, input longint pit,
                                      input longint aoa, input longint q, input longint r,
                                      input longint roll, input longint ax, input longint pil);
    frame_t f;
    f.alt = 24'(alt); f.speed = 16'(spd); f.pitch = 16'(pit); f.aoa = 16'(aoa);
    f.q = 16'(q); f.r = 16'(r); f.roll = 16'(roll); f.ax = 16'(ax); f.pilot = 16'(pil);
    return f;
  endfunction

  // angle or rate: mostly small, sometimes extreme or anything
  function automatic longint rand_q12();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      2, 3: return $signed(16'($urandom));
      default: return longint'($urandom_range(600)) - 300;
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    f = mk_frame(0, 0, rand_q12(), rand_q12(), rand_q12(), rand_q12(), rand_q12(),
                 rand_q12(), longint'($urandom_range(32768)) - 16384);
    case ($urandom_range(9))
      0: f.alt = 24'($urandom);
      1: f.alt = 24'(tgt_alt + longint'($urandom_range(200000)) - 100000);
      default: f.alt = 24'(tgt_alt + longint'($urandom_range(2000)) - 1000);
    endcase
    case ($urandom_range(9))
      0: f.speed = 16'd0;
      1: f.speed = 16'hffff;
      2: f.speed = 16'($urandom);
      default: f.speed = 16'($urandom_range(6000, 1500));
    endcase
    return f;
  endfunction

  // directed frames
  initial begin
    dir_tab[0]  = '{pal_pkg::MODE_NONE, mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 16384), 1'b1,
                    16'sd16384};
    dir_tab[1]  = '{pal_pkg::MODE_NONE, mk_frame(8388607, 65535, 32767, 32767, 32767, 32767,
                    32767, 32767, -16384), 1'b1, -16'sd16384};
    dir_tab[2]  = '{pal_pkg::MODE_NONE, mk_frame(-8388608, 0, -32768, -32768, -32768, -32768,
                    -32768, -32768, 0), 1'b1, 16'sd0};
    dir_tab[3]  = '{MODE_SPARE_LO, mk_frame(100, 3000, 50, 0, 9, 0, 0, 0, 1234), 1'b1,
                    16'sd1234};
    dir_tab[4]  = '{MODE_SPARE_HI, mk_frame(100, 3000, 50, 0, 9, 0, 0, 0, -77), 1'b1,
                    -16'sd77};
    dir_tab[5]  = '{pal_pkg::MODE_PITCH, mk_frame(0, 0, 32767, 0, 0, 0, 0, 0, 0), 1'b1,
                    16'sd16384};
    dir_tab[6]  = '{pal_pkg::MODE_PITCH, mk_frame(0, 0, -32768, 0, 0, 0, 0, 0, 0), 1'b1,
                    -16'sd16384};
    dir_tab[7]  = '{pal_pkg::MODE_PITCH, mk_frame(0, 0, 20, 32767, 40, 32767, 0, 32767, 0),
                    1'b0, 0};
    dir_tab[8]  = '{pal_pkg::MODE_PITCH, mk_frame(0, 0, -10, 0, -30, 200, 6434, 0, 0), 1'b0, 0};
    dir_tab[9]  = '{pal_pkg::MODE_PITCH, mk_frame(0, 0, 0, 0, 32767, -32768, 32767, 0, 0),
                    1'b0, 0};
    dir_tab[10] = '{pal_pkg::MODE_PITCH, mk_frame(0, 0, 0, 0, -32768, 32767, -32768, 0, 0),
                    1'b0, 0};
    dir_tab[11] = '{pal_pkg::MODE_PATH, mk_frame(0, 0, 30, 20, 5, -5, 3217, 0, 0), 1'b0, 0};
    dir_tab[12] = '{pal_pkg::MODE_PATH, mk_frame(0, 0, 0, 0, 0, 0, -12868, 32767, 0), 1'b0, 0};
    dir_tab[13] = '{pal_pkg::MODE_PATH, mk_frame(0, 0, 0, 0, 0, 0, 12868, -32768, 0), 1'b0, 0};
    dir_tab[14] = '{pal_pkg::MODE_PATH, mk_frame(0, 0, 32767, -32768, 0, 0, 0, 0, 0), 1'b0, 0};
    dir_tab[15] = '{pal_pkg::MODE_VS, mk_frame(0, 0, 4, 2, 0, 0, 0, 10, 0), 1'b0, 0};
    dir_tab[16] = '{pal_pkg::MODE_VS, mk_frame(0, 65535, -4, 2, 1, 0, 0, -10, 0), 1'b0, 0};
    dir_tab[17] = '{pal_pkg::MODE_ALT, mk_frame(8388607, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 0};
    dir_tab[18] = '{pal_pkg::MODE_ALT, mk_frame(-8388608, 65535, 0, 0, 0, 0, 0, 0, 0), 1'b0, 0};
    dir_tab[19] = '{pal_pkg::MODE_ALT, mk_frame(30, 3000, 2, 1, 0, 0, 100, 0, 0), 1'b0, 0};
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready      = 1'b0;
    rx_hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      out_ready <= (rst_n && $urandom_range(99) >= rx_stall_pct);
    end
  end

  // check each command against the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cmd_pending_q.size() == 0) begin
        report_mismatch("unexpected elevator_cmd", out_elevator_cmd, 0);
      end else begin
        if (out_elevator_cmd !== cmd_pending_q[0])
          report_mismatch("elevator_cmd", out_elevator_cmd, cmd_pending_q[0]);
        void'(cmd_pending_q.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    logic [2:0] m;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_altitude_down  = '0;
    in_airspeed       = '0;
    in_pitch_angle    = '0;
    in_attack_angle   = '0;
    in_pitch_rate     = '0;
    in_yaw_rate       = '0;
    in_roll_angle     = '0;
    in_forward_accel  = '0;
    in_pilot_elevator = '0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    mism_count        = 0;
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    law_mode = pal_pkg::MODE_NONE;
    tgt_alt = 0; tgt_vs = 0; tgt_pitch = 0; tgt_path = 0;
    pitch_integ = 0; path_integ = 0;
    fill_qsine();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, mode rewritten when a row asks for another one
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].mode != law_mode) begin
        drain();
        write_reg(pal_pkg::CFG_MODE, dir_tab[i].mode);
      end
      send_frame(dir_tab[i].f, dir_tab[i].known, dir_tab[i].cmd);
    end

    // random phases over settings, extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      m = (ph == PHASES - 1) ? 3'($urandom_range(7, 5)) : 3'(pal_pkg::MODE_ALT + (ph % 4));
      write_reg(CFG_NONE_IDX, $urandom);
      case (ph)
        0: begin
          write_reg(pal_pkg::CFG_TGT_ALT, 8388607);
          write_reg(pal_pkg::CFG_TGT_VS, 32767);
          write_reg(pal_pkg::CFG_TGT_PIT, 32767);
          write_reg(pal_pkg::CFG_TGT_PATH, 32767);
        end
        1: begin
          write_reg(pal_pkg::CFG_TGT_ALT, -8388608);
          write_reg(pal_pkg::CFG_TGT_VS, -32768);
          write_reg(pal_pkg::CFG_TGT_PIT, -32768);
          write_reg(pal_pkg::CFG_TGT_PATH, -32768);
        end
        2, 3: begin
          write_reg(pal_pkg::CFG_TGT_ALT, $urandom);
          write_reg(pal_pkg::CFG_TGT_VS, $urandom);
          write_reg(pal_pkg::CFG_TGT_PIT, $urandom);
          write_reg(pal_pkg::CFG_TGT_PATH, $urandom);
        end
        default: begin
          write_reg(pal_pkg::CFG_TGT_ALT, longint'($urandom_range(40000)) - 20000);
          write_reg(pal_pkg::CFG_TGT_VS, longint'($urandom_range(1000)) - 500);
          write_reg(pal_pkg::CFG_TGT_PIT, longint'($urandom_range(400)) - 200);
          write_reg(pal_pkg::CFG_TGT_PATH, longint'($urandom_range(400)) - 200);
        end
      endcase
      write_reg(pal_pkg::CFG_MODE, m);
      // long hold-off so the output fills and the input stalls
      if (ph == 4) rx_hold_cycles = 400;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_frame(rand_frame(), 1'b0, 0);
    end

    drain();
    if (mism_count == 0)
      $display("** pitch_autopilot_elevator_law_unit: PASSED **");
    else
      $display("** pitch_autopilot_elevator_law_unit: FAILED **");
    $finish;
  end

endmodule
